// ===== hdl/rcf_pkg.sv =====
// Shared types and constants for the rainbow color fader.
package rcf_pkg;

  // Channel and register widths
  localparam int LEVEL_W = 8;
  localparam int PHASE_W = 3;
  localparam int TPS_W   = 16;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [PHASE_W-1:0] phase_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } color_t;

  // One result: color after the step and the phase that drove it
  typedef struct packed {
    color_t color;
    phase_t phase;
  } result_t;

  // Phase codes
  localparam phase_t PHASE_RED    = 3'd0;
  localparam phase_t PHASE_YELLOW = 3'd1;
  localparam phase_t PHASE_GREEN  = 3'd2;
  localparam phase_t PHASE_BLUE   = 3'd3;
  localparam phase_t PHASE_INDIGO = 3'd4;
  localparam phase_t PHASE_VIOLET = 3'd5;

  // Levels used by the waypoints and step targets
  localparam level_t LVL_MAX = 8'd255;
  localparam level_t LVL_MID = 8'd128;
  localparam level_t LVL_MIN = 8'd0;

  // Waypoint colors
  localparam color_t WP_RED    = '{red: LVL_MAX, green: LVL_MIN, blue: LVL_MIN};
  localparam color_t WP_YELLOW = '{red: LVL_MAX, green: LVL_MAX, blue: LVL_MIN};
  localparam color_t WP_GREEN  = '{red: LVL_MIN, green: LVL_MID, blue: LVL_MIN};
  localparam color_t WP_BLUE   = '{red: LVL_MIN, green: LVL_MAX, blue: LVL_MAX};
  localparam color_t WP_INDIGO = '{red: LVL_MIN, green: LVL_MIN, blue: LVL_MAX};
  localparam color_t WP_VIOLET = '{red: LVL_MID, green: LVL_MIN, blue: LVL_MID};

  // Reset color and period
  localparam color_t COLOR_RESET = WP_RED;
  localparam logic [TPS_W-1:0] TPS_RESET = 16'd1;

  // Saturating moves towards a target
  function automatic level_t up_to(input level_t v, input level_t limit);
    return (v < limit) ? v + 8'd1 : v;
  endfunction

  function automatic level_t down_to(input level_t v, input level_t limit);
    return (v > limit) ? v - 8'd1 : v;
  endfunction

endpackage

// ===== hdl/rcf_prescaler.sv =====
// Tick prescaler: counts advancing ticks and flags a color step at the period.
module rcf_prescaler #(
  parameter int PRESCALE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tick,
  input  logic [rcf_pkg::TPS_W-1:0] ticks_per_step,
  output logic                      step
);
  import rcf_pkg::*;

  // Compare width covers both the counter span and the period register
  localparam int CW = ((PRESCALE_WIDTH > TPS_W) ? PRESCALE_WIDTH : TPS_W) + 1;

  logic [PRESCALE_WIDTH-1:0] count_r;
  logic [PRESCALE_WIDTH-1:0] count_nxt;
  logic [CW-1:0]             next_ext;
  logic [CW-1:0]             period_raw;
  logic [CW-1:0]             span;
  logic [CW-1:0]             period;
  logic                      wrap;

  // Period: zero counts as one, capped at the counter span
  always_comb begin
    next_ext   = CW'(count_r) + CW'(1);
    period_raw = (ticks_per_step == '0) ? CW'(1) : CW'(ticks_per_step);
    span       = CW'(1) << PRESCALE_WIDTH;
    period     = (period_raw > span) ? span : period_raw;
    wrap       = (next_ext >= period);
    step       = tick && wrap;
    count_nxt  = count_r;
    if (tick) begin
      count_nxt = wrap ? '0 : next_ext[PRESCALE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hdl/rcf_color.sv =====
// Color state: waypoint phase detection and one saturating step per phase.
module rcf_color (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             step,
  output rcf_pkg::result_t result
);
  import rcf_pkg::*;

  color_t color_r;
  color_t color_nxt;
  phase_t phase_r;
  phase_t phase_cur;

  // Phase from the held color; off every waypoint the phase is kept
  always_comb begin
    phase_cur = phase_r;
    if (color_r == WP_VIOLET) phase_cur = PHASE_VIOLET;
    if (color_r == WP_RED)    phase_cur = PHASE_RED;
    if (color_r == WP_YELLOW) phase_cur = PHASE_YELLOW;
    if (color_r == WP_GREEN)  phase_cur = PHASE_GREEN;
    if (color_r == WP_BLUE)   phase_cur = PHASE_BLUE;
    if (color_r == WP_INDIGO) phase_cur = PHASE_INDIGO;
  end

  // Step rules per phase
  always_comb begin
    color_nxt = color_r;
    if (step) begin
      unique case (phase_cur)
        PHASE_RED: begin
          color_nxt.green = up_to(color_r.green, LVL_MAX);
        end
        PHASE_YELLOW: begin
          color_nxt.red   = down_to(color_r.red, LVL_MIN);
          color_nxt.green = down_to(color_r.green, LVL_MID);
          color_nxt.blue  = down_to(color_r.blue, LVL_MIN);
        end
        PHASE_GREEN: begin
          color_nxt.green = up_to(color_r.green, LVL_MAX);
          color_nxt.blue  = up_to(color_r.blue, LVL_MAX);
        end
        PHASE_BLUE: begin
          color_nxt.green = down_to(color_r.green, LVL_MIN);
        end
        PHASE_INDIGO: begin
          color_nxt.red  = up_to(color_r.red, LVL_MID);
          color_nxt.blue = down_to(color_r.blue, LVL_MID);
        end
        PHASE_VIOLET: begin
          color_nxt.red  = up_to(color_r.red, LVL_MAX);
          color_nxt.blue = down_to(color_r.blue, LVL_MIN);
        end
        default: begin
          color_nxt = color_r;
        end
      endcase
    end
  end

  assign result.color = color_nxt;
  assign result.phase = phase_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RESET;
      phase_r <= PHASE_RED;
    end else if (en) begin
      color_r <= color_nxt;
      phase_r <= phase_cur;
    end
  end

endmodule

// ===== hdl/rainbow_color_fader_top.sv =====
// Top level of the rainbow color fader: input register, color logic, result register.
// Rainbow color fader. Every input transfer yields exactly one result transfer holding
// the red, green and blue levels after that item and the fade phase it used. A transfer
// with in_advance high counts one tick; every cfg_wr_data ticks (zero counts as one) the
// color moves at most one level per channel along red, yellow, green, blue, indigo, violet.
// Throughput is one item per clock while out_stall is low: the item waits in the input
// register, then the color and prescaler update as the result is registered, so an item
// passes the input register and the result register before out_valid. Both registers
// advance together whenever the result register is empty or being read; in_stall rises
// only while both are full and out_stall holds. Write cfg_wr_data only while no item is
// in flight.
module rainbow_color_fader_top #(
  parameter int PRESCALE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rcf_pkg::TPS_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_advance,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rcf_pkg::level_t           out_red_level,
  output rcf_pkg::level_t           out_green_level,
  output rcf_pkg::level_t           out_blue_level,
  output rcf_pkg::phase_t           out_fade_phase
);
  import rcf_pkg::*;

  logic [TPS_W-1:0] tps_r;
  logic             in_valid_r;
  logic             advance_r;
  logic             move;
  logic             in_xfer;
  logic             work;
  logic             step;
  result_t          result;
  result_t          out_r;
  logic             out_valid_r;

  // Pipeline advances when the result register is free or being drained
  assign move     = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !move;
  assign in_xfer  = in_valid && !in_stall;
  assign work     = in_valid_r && move;

  // Period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_wr_en) begin
      tps_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (move || !in_valid_r) begin
      in_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      advance_r <= in_advance;
    end
  end

  rcf_prescaler #(
    .PRESCALE_WIDTH(PRESCALE_WIDTH)
  ) u_prescaler (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (work && advance_r),
    .ticks_per_step(tps_r),
    .step          (step)
  );

  rcf_color u_color (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (work),
    .step  (step),
    .result(result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = out_r.color.red;
  assign out_green_level = out_r.color.green;
  assign out_blue_level  = out_r.color.blue;
  assign out_fade_phase  = out_r.phase;

endmodule

// ===== hdl/rcf_checker.sv =====
// Port-level checks for the rainbow color fader, bound to the top level.
module rcf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input rcf_pkg::level_t           out_red_level,
  input rcf_pkg::level_t           out_green_level,
  input rcf_pkg::level_t           out_blue_level,
  input rcf_pkg::phase_t           out_fade_phase
);
  import rcf_pkg::*;

  level_t prev_red_r;
  level_t prev_green_r;
  logic   prev_ok_r;

  // Remember the last transferred levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ok_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      prev_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      prev_red_r   <= out_red_level;
      prev_green_r <= out_green_level;
    end
  end

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_level) &&
      $stable(out_green_level) && $stable(out_blue_level) && $stable(out_fade_phase))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Red moves by at most one level between results
  a_red_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && prev_ok_r |-> (out_red_level == prev_red_r) ||
      (out_red_level == prev_red_r + 8'd1) || (out_red_level == prev_red_r - 8'd1))
    else $error("red jumped by more than one level");

  // Green moves by at most one level between results
  a_green_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && prev_ok_r |-> (out_green_level == prev_green_r) ||
      (out_green_level == prev_green_r + 8'd1) || (out_green_level == prev_green_r - 8'd1))
    else $error("green jumped by more than one level");

endmodule

bind rainbow_color_fader_top rcf_checker u_rcf_checker (.*);

// ===== tb/sv/tb_rainbow_color_fader_top.sv =====
// Testbench for the rainbow color fader: directed table, random ticks, color predictor.
`timescale 1ns / 100ps

module tb_rainbow_color_fader_top;
  import rcf_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD_AT = 250;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned DRAIN_CYCLES = 10;

  // One directed row: optional period write before it, the tick, and a typed-in color
  typedef struct {
    bit              wr_cfg;
    logic [TPS_W-1:0] period;
    bit              advance;
    bit              known;
    result_t         want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [TPS_W-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic                in_advance;
  logic                out_valid;
  logic                out_stall;
  level_t              out_red_level;
  level_t              out_green_level;
  level_t              out_blue_level;
  phase_t              out_fade_phase;

  // Predicted fader state
  level_t              red_q;
  level_t              green_q;
  level_t              blue_q;
  phase_t              phase_q;
  logic [TPS_W-1:0]    prescale_q;
  logic [TPS_W-1:0]    period_q;

  result_t             expected_colors[$];
  dir_row_t            dir_rows[18];
  bit                  steady_flow;
  bit                  long_hold_done;
  bit [7:0]            phases_seen;
  int unsigned         items_sent;
  int unsigned         results_seen;
  int unsigned         color_steps;
  int unsigned         mismatches;

  rainbow_color_fader_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_advance      (in_advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_fade_phase  (out_fade_phase)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_flow || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Saturating one-level move toward a target, in the given direction only
  function automatic level_t nudge(level_t v, level_t tgt, bit rise);
    if (rise) return (v < tgt) ? v + 8'd1 : v;
    return (v > tgt) ? v - 8'd1 : v;
  endfunction

  function automatic dir_row_t dir_row(bit wr, logic [TPS_W-1:0] period, bit adv,
                                       bit known, level_t r, level_t g, level_t b);
    dir_row_t row;
    row.wr_cfg  = wr;
    row.period  = period;
    row.advance = adv;
    row.known   = known;
    row.want    = {r, g, b, PHASE_RED};
    return row;
  endfunction

  // Fader prediction for one tick: phase from the held color, then maybe one step
  task automatic fader_tick(input bit adv, output result_t res);
    color_t      now;
    logic [16:0] wrap_at;
    logic [16:0] next_count;
    now = {red_q, green_q, blue_q};
    if (now == WP_VIOLET)      phase_q = PHASE_VIOLET;
    else if (now == WP_RED)    phase_q = PHASE_RED;
    else if (now == WP_YELLOW) phase_q = PHASE_YELLOW;
    else if (now == WP_GREEN)  phase_q = PHASE_GREEN;
    else if (now == WP_BLUE)   phase_q = PHASE_BLUE;
    else if (now == WP_INDIGO) phase_q = PHASE_INDIGO;
    if (adv) begin
      // a zero period counts as one
      wrap_at    = (period_q == '0) ? 17'd1 : {1'b0, period_q};
      next_count = {1'b0, prescale_q} + 17'd1;
      if (next_count >= wrap_at) begin
        prescale_q = '0;
        color_steps++;
        case (phase_q)
          PHASE_RED: begin
            green_q = nudge(green_q, LVL_MAX, 1'b1);
          end
          PHASE_YELLOW: begin
            red_q   = nudge(red_q, LVL_MIN, 1'b0);
            green_q = nudge(green_q, LVL_MID, 1'b0);
            blue_q  = nudge(blue_q, LVL_MIN, 1'b0);
          end
          PHASE_GREEN: begin
            green_q = nudge(green_q, LVL_MAX, 1'b1);
            blue_q  = nudge(blue_q, LVL_MAX, 1'b1);
          end
          PHASE_BLUE: begin
            green_q = nudge(green_q, LVL_MIN, 1'b0);
          end
          PHASE_INDIGO: begin
            red_q  = nudge(red_q, LVL_MID, 1'b1);
            blue_q = nudge(blue_q, LVL_MID, 1'b0);
          end
          PHASE_VIOLET: begin
            red_q  = nudge(red_q, LVL_MAX, 1'b1);
            blue_q = nudge(blue_q, LVL_MIN, 1'b0);
          end
          default: begin
          end
        endcase
      end else begin
        prescale_q = next_count[TPS_W-1:0];
      end
    end
    phases_seen[phase_q] = 1'b1;
    res = {red_q, green_q, blue_q, phase_q};
  endtask

  // Offer one tick (called at a falling edge); returns at the falling edge after the transfer
  task automatic send_tick(input bit adv, input bit known, input result_t want);
    int unsigned gap;
    result_t     res;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_advance <= adv;
    fader_tick(adv, res);
    expected_colors.push_back(known ? want : res);
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected color has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Period write while idle; the prescaler count is kept across it
  task automatic write_period(input logic [TPS_W-1:0] period);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= period;
    period_q     = period;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_segment(input logic [TPS_W-1:0] period, input int unsigned count,
                             input bit steady);
    drain_results();
    write_period(period);
    steady_flow = steady;
    repeat (count) send_tick($urandom_range(0, 31) != 0, 1'b0, '0);
  endtask

  // Stimulus: reset, directed table, random segments, end of run
  initial begin : stimulus
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_advance     = 1'b0;
    steady_flow    = 1'b0;
    long_hold_done = 1'b0;
    phases_seen    = '0;
    items_sent     = 0;
    results_seen   = 0;
    color_steps    = 0;
    mismatches     = 0;
    red_q          = COLOR_RESET.red;
    green_q        = COLOR_RESET.green;
    blue_q         = COLOR_RESET.blue;
    phase_q        = PHASE_RED;
    prescale_q     = '0;
    period_q       = TPS_RESET;

    // reset state, idle ticks, zero period, prescaler counting, max period then lowered
    dir_rows = '{
      dir_row(1'b0, 16'd0,     1'b0, 1'b1, 8'd255, 8'd0, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b1, 8'd255, 8'd1, 8'd0),
      dir_row(1'b0, 16'd0,     1'b0, 1'b1, 8'd255, 8'd1, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b1, 8'd255, 8'd2, 8'd0),
      dir_row(1'b1, 16'd0,     1'b1, 1'b1, 8'd255, 8'd3, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b1, 8'd255, 8'd4, 8'd0),
      dir_row(1'b1, 16'd3,     1'b1, 1'b0, 8'd0,   8'd0, 8'd0),
      dir_row(1'b0, 16'd0,     1'b0, 1'b0, 8'd0,   8'd0, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   8'd0, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   8'd0, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   8'd0, 8'd0),
      dir_row(1'b1, 16'hFFFF,  1'b1, 1'b0, 8'd0,   8'd0, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   8'd0, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b0, 8'd0,   8'd0, 8'd0),
      dir_row(1'b1, 16'd1,     1'b1, 1'b1, 8'd255, 8'd6, 8'd0),
      dir_row(1'b1, 16'd2,     1'b1, 1'b1, 8'd255, 8'd6, 8'd0),
      dir_row(1'b0, 16'd0,     1'b1, 1'b1, 8'd255, 8'd7, 8'd0),
      dir_row(1'b1, 16'd1,     1'b1, 1'b1, 8'd255, 8'd8, 8'd0)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cfg) begin
        drain_results();
        write_period(dir_rows[i].period);
      end
      send_tick(dir_rows[i].advance, dir_rows[i].known, dir_rows[i].want);
    end

    // Random part: long fast runs carry the color through most of the phases
    run_segment(16'd0,     520, 1'b0);
    run_segment(16'd3,      45, 1'b1);
    run_segment(16'hFFFF,   20, 1'b0);
    run_segment(16'd1,     520, 1'b0);
    run_segment(16'd2,      30, 1'b1);
    run_segment(16'h5A5A,   10, 1'b0);

    steady_flow = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d ticks and %0d checked colors, %0d color steps",
             items_sent, results_seen, color_steps);
    $display("phases seen %b, periods 0, 1, 2, 3, 0x5a5a and 0xffff", phases_seen[5:0]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stall, one long hold-off, field checks at the rising edge
  initial begin : receiver
    int unsigned hold;
    result_t     want;
    hold      = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_colors.size() == 0) begin
          $error("color transfer with nothing expected");
          mismatches++;
        end else begin
          want = expected_colors.pop_front();
          if (out_red_level !== want.color.red) begin
            $error("red_level: expected %0d, got %0d", want.color.red, out_red_level);
            mismatches++;
          end
          if (out_green_level !== want.color.green) begin
            $error("green_level: expected %0d, got %0d", want.color.green, out_green_level);
            mismatches++;
          end
          if (out_blue_level !== want.color.blue) begin
            $error("blue_level: expected %0d, got %0d", want.color.blue, out_blue_level);
            mismatches++;
          end
          if (out_fade_phase !== want.phase) begin
            $error("fade_phase: expected %0d, got %0d", want.phase, out_fade_phase);
            mismatches++;
          end
        end
      end
      @(negedge clk);
      // long hold-off so the pipe fills and the input backs up
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (hold == 0 && !steady_flow && $urandom_range(0, 3) == 0) begin
        hold = pick_gap();
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

endmodule
